/* rtl/idc_pkg.sv */
`timescale 1ns / 1ps
// idc_pkg: shared widths, types and register codes for the image diff compare block
// no dependencies; used by every other file of the block

package idc_pkg;

  localparam int MAX_EXTENT = 16384;
  // tap extent holds MAX_EXTENT itself, a position stays below it
  localparam int EXT_W = $clog2(MAX_EXTENT + 1);
  localparam int POS_W = $clog2(MAX_EXTENT);

  localparam int PIX_W = 32;
  localparam int CH_W = 8;
  localparam int NUM_CH = PIX_W / CH_W;
  localparam int ORG_W = 14;
  localparam int SIZE_W = 15;
  localparam int COORD_W = 15;
  localparam int CNT_W = 29;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [CH_W-1:0] chan_t;
  typedef logic [ORG_W-1:0] org_t;
  typedef logic [SIZE_W-1:0] size_t;
  typedef logic [EXT_W-1:0] ext_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam cnt_t COUNT_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X   = 2'd0,
    REG_ORIGIN_Y   = 2'd1,
    REG_TAP_WIDTH  = 2'd2,
    REG_TAP_HEIGHT = 2'd3
  } cfg_reg_t;

  // settings as seen by the datapath
  typedef struct packed {
    org_t origin_x;
    org_t origin_y;
    ext_t w_eff;
    ext_t h_eff;
  } cfg_t;

  // registered input item with its channel difference
  typedef struct packed {
    pix_t  prod;
    pix_t  refp;
    logic  mask;
    chan_t diff;
  } stage_t;

  typedef struct packed {
    cnt_t   wrong_count;
    chan_t  worst_diff;
    coord_t bbox_x;
    coord_t bbox_y;
    coord_t bbox_width;
    coord_t bbox_height;
    logic   sample_found;
    coord_t sample_x;
    coord_t sample_y;
    pix_t   sample_prod;
    pix_t   sample_ref;
  } res_t;

endpackage

/* rtl/idc_ifs.sv */
`timescale 1ns / 1ps
// idc_ifs: valid/ready channel interfaces for pixel items, result items and config writes
// depends on idc_pkg

interface idc_pix_if;
  logic                valid;
  logic                ready;
  idc_pkg::pix_t       prod_pixel;
  idc_pkg::pix_t       ref_pixel;
  logic                in_mask;

  modport source (output valid, output prod_pixel, output ref_pixel, output in_mask,
                  input ready);
  modport sink (input valid, input prod_pixel, input ref_pixel, input in_mask,
                output ready);
endinterface

interface idc_res_if;
  logic                valid;
  logic                ready;
  idc_pkg::cnt_t       wrong_count;
  idc_pkg::chan_t      worst_diff;
  idc_pkg::coord_t     bbox_x;
  idc_pkg::coord_t     bbox_y;
  idc_pkg::coord_t     bbox_width;
  idc_pkg::coord_t     bbox_height;
  logic                sample_found;
  idc_pkg::coord_t     sample_x;
  idc_pkg::coord_t     sample_y;
  idc_pkg::pix_t       sample_prod;
  idc_pkg::pix_t       sample_ref;

  modport source (output valid, output wrong_count, output worst_diff, output bbox_x,
                  output bbox_y, output bbox_width, output bbox_height,
                  output sample_found, output sample_x, output sample_y,
                  output sample_prod, output sample_ref, input ready);
  modport sink (input valid, input wrong_count, input worst_diff, input bbox_x,
                input bbox_y, input bbox_width, input bbox_height,
                input sample_found, input sample_x, input sample_y,
                input sample_prod, input sample_ref, output ready);
endinterface

interface idc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [idc_pkg::CFG_IDX_W-1:0]       index;
  logic [idc_pkg::CFG_DATA_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/idc_cfg_regs.sv */
`timescale 1ns / 1ps
// idc_cfg_regs: tap geometry registers and their clamped extents
// depends on idc_pkg and idc_cfg_if

module idc_cfg_regs (
  input  logic           clk,
  input  logic           rst_n,
  idc_cfg_if.sink        cfg_ch,
  output idc_pkg::cfg_t  cfg
);

  idc_pkg::org_t  origin_x_r;
  idc_pkg::org_t  origin_y_r;
  idc_pkg::size_t tap_width_r;
  idc_pkg::size_t tap_height_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r   <= '0;
      origin_y_r   <= '0;
      tap_width_r  <= idc_pkg::size_t'(1);
      tap_height_r <= idc_pkg::size_t'(1);
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (idc_pkg::cfg_reg_t'(cfg_ch.index))
        idc_pkg::REG_ORIGIN_X:   origin_x_r   <= cfg_ch.data[idc_pkg::ORG_W-1:0];
        idc_pkg::REG_ORIGIN_Y:   origin_y_r   <= cfg_ch.data[idc_pkg::ORG_W-1:0];
        idc_pkg::REG_TAP_WIDTH:  tap_width_r  <= cfg_ch.data[idc_pkg::SIZE_W-1:0];
        idc_pkg::REG_TAP_HEIGHT: tap_height_r <= cfg_ch.data[idc_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero reads as one, oversize clamps to the maximum extent
  function automatic idc_pkg::ext_t eff_extent(input idc_pkg::size_t v);
    idc_pkg::ext_t r;
    if (v == '0) begin
      r = idc_pkg::ext_t'(1);
    end else if (int'(v) > idc_pkg::MAX_EXTENT) begin
      r = idc_pkg::ext_t'(idc_pkg::MAX_EXTENT);
    end else begin
      r = idc_pkg::ext_t'(v);
    end
    return r;
  endfunction

  always_comb begin
    cfg.origin_x = origin_x_r;
    cfg.origin_y = origin_y_r;
    cfg.w_eff    = eff_extent(tap_width_r);
    cfg.h_eff    = eff_extent(tap_height_r);
  end

endmodule

/* rtl/idc_diff_stage.sv */
`timescale 1ns / 1ps
// idc_diff_stage: input register with the per-pixel largest channel difference
// depends on idc_pkg and idc_pix_if

module idc_diff_stage (
  input  logic             clk,
  input  logic             rst_n,
  idc_pix_if.sink          in_ch,
  input  logic             adv,
  output idc_pkg::stage_t  stg,
  output logic             stg_valid
);

  logic            valid_r;
  idc_pkg::stage_t stg_r;
  idc_pkg::stage_t stg_nxt;

  assign in_ch.ready = !valid_r || adv;

  always_comb begin
    idc_pkg::chan_t ca;
    idc_pkg::chan_t cb;
    idc_pkg::chan_t d;
    idc_pkg::chan_t worst;
    worst = '0;
    for (int ch = 0; ch < idc_pkg::NUM_CH; ch++) begin
      ca = in_ch.prod_pixel[ch*idc_pkg::CH_W +: idc_pkg::CH_W];
      cb = in_ch.ref_pixel[ch*idc_pkg::CH_W +: idc_pkg::CH_W];
      d  = (ca > cb) ? ca - cb : cb - ca;
      if (d > worst) begin
        worst = d;
      end
    end
    stg_nxt.prod = in_ch.prod_pixel;
    stg_nxt.refp = in_ch.ref_pixel;
    stg_nxt.mask = in_ch.in_mask;
    stg_nxt.diff = worst;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stg_r <= stg_nxt;
    end
  end

  assign stg       = stg_r;
  assign stg_valid = valid_r;

endmodule

/* rtl/idc_accum.sv */
`timescale 1ns / 1ps
// idc_accum: raster position, mismatch accumulators and the result register
// depends on idc_pkg and idc_res_if

module idc_accum (
  input  logic             clk,
  input  logic             rst_n,
  input  idc_pkg::cfg_t    cfg,
  input  idc_pkg::stage_t  stg,
  input  logic             stg_valid,
  output logic             adv,
  idc_res_if.source        out_ch
);

  // control state
  idc_pkg::pos_t   col_r, col_nxt;
  idc_pkg::pos_t   row_r, row_nxt;
  idc_pkg::cnt_t   cnt_r, cnt_nxt;
  idc_pkg::chan_t  worst_r, worst_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r;
  // payload state
  idc_pkg::pos_t   min_col_r, min_col_nxt;
  idc_pkg::pos_t   min_row_r, min_row_nxt;
  idc_pkg::ext_t   end_col_r, end_col_nxt;
  idc_pkg::ext_t   end_row_r, end_row_nxt;
  idc_pkg::coord_t first_x_r, first_x_nxt;
  idc_pkg::coord_t first_y_r, first_y_nxt;
  idc_pkg::pix_t   first_prod_r, first_prod_nxt;
  idc_pkg::pix_t   first_ref_r, first_ref_nxt;
  idc_pkg::res_t   res_r, res_nxt;

  idc_pkg::ext_t   col_inc;
  idc_pkg::ext_t   row_inc;
  logic            row_end;
  logic            tap_end;
  logic            hit;

  assign col_inc = idc_pkg::ext_t'(col_r) + idc_pkg::ext_t'(1);
  assign row_inc = idc_pkg::ext_t'(row_r) + idc_pkg::ext_t'(1);
  assign row_end = col_inc >= cfg.w_eff;
  assign tap_end = row_end && (row_inc >= cfg.h_eff);
  assign hit     = stg.mask && (stg.diff != '0);

  // the result slot must be free or draining before the last pixel of a tap moves on
  assign adv = stg_valid && (!tap_end || !out_valid_r || out_ch.ready);

  // accumulator update for the current pixel
  always_comb begin
    cnt_nxt        = cnt_r;
    worst_nxt      = worst_r;
    found_nxt      = found_r;
    min_col_nxt    = min_col_r;
    min_row_nxt    = min_row_r;
    end_col_nxt    = end_col_r;
    end_row_nxt    = end_row_r;
    first_x_nxt    = first_x_r;
    first_y_nxt    = first_y_r;
    first_prod_nxt = first_prod_r;
    first_ref_nxt  = first_ref_r;
    if (hit) begin
      if (cnt_r != idc_pkg::COUNT_MAX) begin
        cnt_nxt = cnt_r + idc_pkg::cnt_t'(1);
      end
      if (stg.diff > worst_r) begin
        worst_nxt = stg.diff;
      end
      if (!found_r) begin
        found_nxt      = 1'b1;
        first_x_nxt    = idc_pkg::coord_t'(cfg.origin_x) + idc_pkg::coord_t'(col_r);
        first_y_nxt    = idc_pkg::coord_t'(cfg.origin_y) + idc_pkg::coord_t'(row_r);
        first_prod_nxt = stg.prod;
        first_ref_nxt  = stg.refp;
        min_col_nxt    = col_r;
        min_row_nxt    = row_r;
        end_col_nxt    = col_inc;
        end_row_nxt    = row_inc;
      end else begin
        if (col_r < min_col_r) min_col_nxt = col_r;
        if (row_r < min_row_r) min_row_nxt = row_r;
        if (col_inc > end_col_r) end_col_nxt = col_inc;
        if (row_inc > end_row_r) end_row_nxt = row_inc;
      end
    end
  end

  // next raster position
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (tap_end) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_inc[idc_pkg::POS_W-1:0];
    end else begin
      col_nxt = col_inc[idc_pkg::POS_W-1:0];
    end
  end

  // result built from the state after the tap's last pixel
  always_comb begin
    res_nxt.wrong_count  = cnt_nxt;
    res_nxt.worst_diff   = worst_nxt;
    res_nxt.sample_found = found_nxt;
    if (found_nxt) begin
      res_nxt.bbox_x      = idc_pkg::coord_t'(cfg.origin_x) + idc_pkg::coord_t'(min_col_nxt);
      res_nxt.bbox_y      = idc_pkg::coord_t'(cfg.origin_y) + idc_pkg::coord_t'(min_row_nxt);
      res_nxt.bbox_width  = idc_pkg::coord_t'(end_col_nxt - idc_pkg::ext_t'(min_col_nxt));
      res_nxt.bbox_height = idc_pkg::coord_t'(end_row_nxt - idc_pkg::ext_t'(min_row_nxt));
      res_nxt.sample_x    = first_x_nxt;
      res_nxt.sample_y    = first_y_nxt;
      res_nxt.sample_prod = first_prod_nxt;
      res_nxt.sample_ref  = first_ref_nxt;
    end else begin
      res_nxt.bbox_x      = '0;
      res_nxt.bbox_y      = '0;
      res_nxt.bbox_width  = '0;
      res_nxt.bbox_height = '0;
      res_nxt.sample_x    = '0;
      res_nxt.sample_y    = '0;
      res_nxt.sample_prod = '0;
      res_nxt.sample_ref  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r       <= '0;
      row_r       <= '0;
      cnt_r       <= '0;
      worst_r     <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
        if (tap_end) begin
          cnt_r   <= '0;
          worst_r <= '0;
          found_r <= 1'b0;
        end else begin
          cnt_r   <= cnt_nxt;
          worst_r <= worst_nxt;
          found_r <= found_nxt;
        end
      end
      if (adv && tap_end) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      min_col_r    <= min_col_nxt;
      min_row_r    <= min_row_nxt;
      end_col_r    <= end_col_nxt;
      end_row_r    <= end_row_nxt;
      first_x_r    <= first_x_nxt;
      first_y_r    <= first_y_nxt;
      first_prod_r <= first_prod_nxt;
      first_ref_r  <= first_ref_nxt;
    end
    if (adv && tap_end) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.wrong_count  = res_r.wrong_count;
  assign out_ch.worst_diff   = res_r.worst_diff;
  assign out_ch.bbox_x       = res_r.bbox_x;
  assign out_ch.bbox_y       = res_r.bbox_y;
  assign out_ch.bbox_width   = res_r.bbox_width;
  assign out_ch.bbox_height  = res_r.bbox_height;
  assign out_ch.sample_found = res_r.sample_found;
  assign out_ch.sample_x     = res_r.sample_x;
  assign out_ch.sample_y     = res_r.sample_y;
  assign out_ch.sample_prod  = res_r.sample_prod;
  assign out_ch.sample_ref   = res_r.sample_ref;

endmodule

/* rtl/image_diff_compare_unit.sv */
`timescale 1ns / 1ps
// image_diff_compare_unit: top level of the streaming image compare block
// depends on idc_pkg, idc_ifs, idc_cfg_regs, idc_diff_stage and idc_accum
//
// in_ch carries one pixel pair per item (production, reference, mask bit) in raster
// order over the tap rectangle set by the cfg_ch registers (origin x/y, width,
// height; a zero extent counts as one, larger ones clamp to the maximum extent).
// out_ch carries one item per tap, after its last pixel: wrong count, worst
// difference, bounding box in image coordinates and the first differing pixel.
// Throughput: one pixel item per cycle while out_ch does not hold back the
// last pixel of a tap.
// The tap's last pixel goes through the diff stage register, and then its result
// goes into the result register, which raises out_ch valid; a pending result can
// hold that second step back.
// When out_ch stalls, the finished result waits in the result register while the
// next tap's pixels keep streaming; only the next tap's last pixel waits for it.
// Reset clears the position counters, accumulators and both valid flags and sets
// the registers to origin 0,0 and a 1x1 tap. cfg_ch is always ready; write it only
// while no tap is in progress.

module image_diff_compare_unit (
  input  logic      clk,
  input  logic      rst_n,
  idc_pix_if.sink   in_ch,
  idc_res_if.source out_ch,
  idc_cfg_if.sink   cfg_ch
);

  idc_pkg::cfg_t   cfg;
  idc_pkg::stage_t stg;
  logic            stg_valid;
  logic            adv;

  idc_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  idc_diff_stage u_diff (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .adv       (adv),
    .stg       (stg),
    .stg_valid (stg_valid)
  );

  idc_accum u_acc (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg       (stg),
    .stg_valid (stg_valid),
    .adv       (adv),
    .out_ch    (out_ch)
  );

  // a held pixel in the diff stage blocks new input
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (stg_valid && !adv) |-> !in_ch.ready)
    else $error("input accepted while diff stage is stalled");

  // no differing pixel means an empty box and an empty sample
  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.sample_found) |->
      (out_ch.wrong_count == '0 && out_ch.bbox_width == '0 && out_ch.bbox_height == '0
       && out_ch.sample_prod == '0 && out_ch.sample_ref == '0))
    else $error("result without a sample carries nonzero fields");

  // a found sample implies a count, a difference and a nonempty box
  a_found_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.sample_found) |->
      (out_ch.wrong_count != '0 && out_ch.worst_diff != '0
       && out_ch.bbox_width != '0 && out_ch.bbox_height != '0
       && out_ch.sample_prod != out_ch.sample_ref))
    else $error("result with a sample has inconsistent fields");

  // a new result is only produced into a free or draining slot
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable(out_ch.wrong_count)))
    else $error("pending result overwritten");

endmodule
